/* rtl/core/idl_pkg.sv */
// Shared types and constants for the indexed deque list unit.
package idl_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 9;

	// Command codes carried in the command field of an input word.
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_INSERT     = 3'd1,
		CMD_PUSH_BACK  = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_DELETE     = 3'd4,
		CMD_POP_BACK   = 3'd5,
		CMD_SEARCH     = 3'd6,
		CMD_NONE       = 3'd7
	} cmd_t;

	// Status codes reported with every result word.
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Input word.
	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] data_value;
		logic [7:0]               position;
	} item_t;

	// Result word.
	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [COUNT_W-1:0] count;
	} result_t;

	// Source for loading the element iterator.
	typedef enum logic [1:0] {
		ITS_ZERO = 2'd0,
		ITS_CNT  = 2'd1,
		ITS_POS  = 2'd2
	} itsel_t;

	// Read address relative to the iterator.
	typedef enum logic [1:0] {
		REL_PREV = 2'd0,
		REL_CUR  = 2'd1,
		REL_NEXT = 2'd2
	} rel_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE     = 4'd0,
		S_DECIDE   = 4'd1,
		S_PUT      = 4'd2,
		S_INS_CHK  = 4'd3,
		S_INS_WR   = 4'd4,
		S_DEL_CHK  = 4'd5,
		S_DEL_WR   = 4'd6,
		S_SRCH_CHK = 4'd7,
		S_SRCH_CMP = 4'd8
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       it_load;
		itsel_t     it_sel;
		logic       it_inc;
		logic       it_dec;
		logic       rd_en;
		rel_t       rd_rel;
		logic       wr_en;
		logic       wr_val;
		logic       head_inc;
		logic       head_dec;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_en;
		logic [1:0] res_status;
		logic       res_found;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic full;
		logic pos_bad;
		logic it_gt_pos;
		logic it_lt_last;
		logic it_lt_cnt;
		logic match;
	} sts_t;

endpackage

/* rtl/core/idl_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module idl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/idl_ctrl.sv */
// Controller state machine that sequences each command over the datapath.
module idl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  idl_pkg::sts_t sts,
	output logic          busy,
	output idl_pkg::ctl_t ctl
);

	import idl_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (sts.cmd)
					CMD_PUSH_FRONT: begin
						if (sts.full) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = ST_FULL;
							state_d        = S_IDLE;
						end else begin
							ctl.head_dec = 1'b1;
							ctl.it_load  = 1'b1;
							ctl.it_sel   = ITS_ZERO;
							state_d      = S_PUT;
						end
					end
					CMD_INSERT: begin
						if (sts.empty) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = ST_EMPTY;
							state_d        = S_IDLE;
						end else if (sts.pos_bad) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = ST_BADPOS;
							state_d        = S_IDLE;
						end else if (sts.full) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = ST_FULL;
							state_d        = S_IDLE;
						end else begin
							ctl.it_load = 1'b1;
							ctl.it_sel  = ITS_CNT;
							state_d     = S_INS_CHK;
						end
					end
					CMD_PUSH_BACK: begin
						if (sts.full) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = ST_FULL;
							state_d        = S_IDLE;
						end else begin
							ctl.it_load = 1'b1;
							ctl.it_sel  = ITS_CNT;
							state_d     = S_PUT;
						end
					end
					CMD_POP_FRONT: begin
						ctl.res_en = 1'b1;
						state_d    = S_IDLE;
						if (sts.empty) begin
							ctl.res_status = ST_EMPTY;
						end else begin
							ctl.res_status = ST_OK;
							ctl.head_inc   = 1'b1;
							ctl.cnt_dec    = 1'b1;
						end
					end
					CMD_DELETE: begin
						if (sts.empty) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = ST_EMPTY;
							state_d        = S_IDLE;
						end else if (sts.pos_bad) begin
							ctl.res_en     = 1'b1;
							ctl.res_status = ST_BADPOS;
							state_d        = S_IDLE;
						end else begin
							ctl.it_load = 1'b1;
							ctl.it_sel  = ITS_POS;
							state_d     = S_DEL_CHK;
						end
					end
					CMD_POP_BACK: begin
						ctl.res_en = 1'b1;
						state_d    = S_IDLE;
						if (sts.empty) begin
							ctl.res_status = ST_EMPTY;
						end else begin
							ctl.res_status = ST_OK;
							ctl.cnt_dec    = 1'b1;
						end
					end
					CMD_SEARCH: begin
						ctl.it_load = 1'b1;
						ctl.it_sel  = ITS_ZERO;
						state_d     = S_SRCH_CHK;
					end
					default: begin
						// The unused code only reports the current count.
						ctl.res_en     = 1'b1;
						ctl.res_status = ST_OK;
						state_d        = S_IDLE;
					end
				endcase
			end
			S_PUT: begin
				ctl.wr_en      = 1'b1;
				ctl.wr_val     = 1'b1;
				ctl.cnt_inc    = 1'b1;
				ctl.res_en     = 1'b1;
				ctl.res_status = ST_OK;
				state_d        = S_IDLE;
			end
			S_INS_CHK: begin
				// Move the tail back one slot until the gap reaches the position.
				if (sts.it_gt_pos) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_rel = REL_PREV;
					state_d    = S_INS_WR;
				end else begin
					state_d = S_PUT;
				end
			end
			S_INS_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.it_dec = 1'b1;
				state_d    = S_INS_CHK;
			end
			S_DEL_CHK: begin
				// Pull later elements forward one slot to close the gap.
				if (sts.it_lt_last) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_rel = REL_NEXT;
					state_d    = S_DEL_WR;
				end else begin
					ctl.cnt_dec    = 1'b1;
					ctl.res_en     = 1'b1;
					ctl.res_status = ST_OK;
					state_d        = S_IDLE;
				end
			end
			S_DEL_WR: begin
				ctl.wr_en  = 1'b1;
				ctl.it_inc = 1'b1;
				state_d    = S_DEL_CHK;
			end
			S_SRCH_CHK: begin
				if (sts.it_lt_cnt) begin
					ctl.rd_en  = 1'b1;
					ctl.rd_rel = REL_CUR;
					state_d    = S_SRCH_CMP;
				end else begin
					ctl.res_en     = 1'b1;
					ctl.res_status = ST_OK;
					state_d        = S_IDLE;
				end
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					ctl.res_en     = 1'b1;
					ctl.res_status = ST_OK;
					ctl.res_found  = 1'b1;
					state_d        = S_IDLE;
				end else begin
					ctl.it_inc = 1'b1;
					state_d    = S_SRCH_CHK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

/* rtl/core/idl_dp.sv */
// Datapath: held command word, head pointer, count, iterator, addressing and results.
module idl_dp #(
	parameter int CAPACITY = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  idl_pkg::item_t              item,
	input  idl_pkg::ctl_t               ctl,
	output idl_pkg::sts_t               sts,
	output logic                        ram_we,
	output logic [$clog2(CAPACITY)-1:0] ram_waddr,
	output logic [idl_pkg::DATA_W-1:0]  ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(CAPACITY)-1:0] ram_raddr,
	input  logic [idl_pkg::DATA_W-1:0]  ram_rdata,
	output idl_pkg::result_t            result,
	output logic                        done
);

	import idl_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = CW + 1;
	localparam int PW = (CW > 8) ? CW : 8;

	item_t         item_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [CW-1:0] it_q;
	logic [CW-1:0] rd_idx;
	result_t       result_q;
	logic          done_q;

	// Map a logical position onto a slot of the circular store.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] idx);
		logic [SW-1:0] s;
		s = SW'(h) + SW'(idx);
		if (s >= SW'(CAPACITY)) begin
			s = s - SW'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	// Held command word.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= item;
		end
	end

	// Next count.
	always_comb begin
		cnt_d = cnt_q;
		if (ctl.cnt_inc) begin
			cnt_d = cnt_q + CW'(1);
		end else if (ctl.cnt_dec) begin
			cnt_d = cnt_q - CW'(1);
		end
	end

	// Head pointer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (ctl.head_inc) begin
				head_q <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
			end else if (ctl.head_dec) begin
				head_q <= (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
			end
		end
	end

	// Element iterator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (ctl.it_load) begin
			case (ctl.it_sel)
				ITS_ZERO: it_q <= '0;
				ITS_CNT:  it_q <= cnt_q;
				ITS_POS:  it_q <= CW'(PW'(item_q.position));
				default:  it_q <= '0;
			endcase
		end else if (ctl.it_inc) begin
			it_q <= it_q + CW'(1);
		end else if (ctl.it_dec) begin
			it_q <= it_q - CW'(1);
		end
	end

	// Store addressing.
	always_comb begin
		case (ctl.rd_rel)
			REL_PREV: rd_idx = it_q - CW'(1);
			REL_CUR:  rd_idx = it_q;
			REL_NEXT: rd_idx = it_q + CW'(1);
			default:  rd_idx = it_q;
		endcase
	end

	assign ram_re    = ctl.rd_en;
	assign ram_raddr = phys(head_q, rd_idx);
	assign ram_we    = ctl.wr_en;
	assign ram_waddr = phys(head_q, it_q);
	assign ram_wdata = ctl.wr_val ? item_q.data_value : ram_rdata;

	// Status toward the controller.
	always_comb begin
		sts.cmd        = cmd_t'(item_q.command);
		sts.empty      = (cnt_q == '0);
		sts.full       = (cnt_q == CW'(CAPACITY));
		sts.pos_bad    = (item_q.position == '0) ||
		                 (PW'(item_q.position) >= PW'(cnt_q));
		sts.it_gt_pos  = (PW'(it_q) > PW'(item_q.position));
		sts.it_lt_last = ((SW'(it_q) + SW'(1)) < SW'(cnt_q));
		sts.it_lt_cnt  = (it_q < cnt_q);
		sts.match      = (ram_rdata == item_q.data_value);
	end

	// Result word, carrying the count after the command.
	always_ff @(posedge clk) begin
		if (ctl.res_en) begin
			result_q.status <= ctl.res_status;
			result_q.found  <= ctl.res_found;
			result_q.count  <= COUNT_W'(cnt_d);
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.res_en;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

/* rtl/core/indexed_deque_list_unit.sv */
// Indexed deque list unit: a bounded ordered list of 32-bit values.
//
// Usage: present a command word on item and raise start; the word is taken at
// a clock edge where start is high and busy is low. busy stays high until the
// command has finished. Exactly one result word follows each command: done is
// high for one cycle and result holds the status, the found flag and the
// element count after the command. The receiver cannot stall; a result is
// gone after its cycle. A new command may be started in the cycle that done
// is high.
// Elements sit in one RAM used as a circular buffer, so the ends move in
// place; inserts, deletes and searches walk the RAM one element at a time
// (a registered read, then a write or a compare).
// Reset empties the list at once; the store itself is never cleared.
module indexed_deque_list_unit #(
	parameter int CAPACITY = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  idl_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output idl_pkg::result_t result
);

	import idl_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	ctl_t              ctl;
	sts_t              sts;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	// Sequencer.
	idl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Datapath.
	idl_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ctl       (ctl),
		.sts       (sts),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.result    (result),
		.done      (done)
	);

	// Element store.
	idl_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A result word only appears once the sequencer is back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted command always raises busy in the cycle after it is taken.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// Only a successful search reports found.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.found) |-> (result.status == ST_OK))
		else $error("found flag with error status");

	// The count never exceeds the capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((CAPACITY > 511) || (result.count <= COUNT_W'(CAPACITY))))
		else $error("count above capacity");

endmodule

/* sim/idl_list_checker.sv */
// Checker for the indexed deque list unit: predicts each result word and compares it.
module idl_list_checker #(
	parameter int CAPACITY = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  idl_pkg::item_t   item,
	input  logic             done,
	input  idl_pkg::result_t result,
	output int               mismatches,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import idl_pkg::*;

	// Shadow copy of the list, front at index 0, and the results still owed.
	logic signed [DATA_W-1:0] contents [$];
	result_t                  results_due [$];
	result_t                  due;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// Apply one command word to the shadow list and return the result it owes.
	function automatic result_t apply_command(input item_t w);
		result_t r;
		int      n;
		n = contents.size();
		r = '0;
		r.status = ST_OK;
		case (cmd_t'(w.command))
			CMD_PUSH_FRONT: begin
				if (n >= CAPACITY) r.status = ST_FULL;
				else contents.push_front(w.data_value);
			end
			CMD_INSERT: begin
				if (n == 0) r.status = ST_EMPTY;
				else if (w.position == 0 || w.position >= n) r.status = ST_BADPOS;
				else if (n >= CAPACITY) r.status = ST_FULL;
				else contents.insert(w.position, w.data_value);
			end
			CMD_PUSH_BACK: begin
				if (n >= CAPACITY) r.status = ST_FULL;
				else contents.push_back(w.data_value);
			end
			CMD_POP_FRONT: begin
				if (n == 0) r.status = ST_EMPTY;
				else void'(contents.pop_front());
			end
			CMD_DELETE: begin
				if (n == 0) r.status = ST_EMPTY;
				else if (w.position == 0 || w.position >= n) r.status = ST_BADPOS;
				else contents.delete(w.position);
			end
			CMD_POP_BACK: begin
				if (n == 0) r.status = ST_EMPTY;
				else void'(contents.pop_back());
			end
			CMD_SEARCH: begin
				foreach (contents[i])
					if (contents[i] == w.data_value) r.found = 1'b1;
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(contents.size());
		return r;
	endfunction

	// Count a failure; only the first ten get a line of their own.
	task automatic note_failure(input string what);
		mismatches++;
		if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
	endtask

	// Check the result word of this cycle first, then take in a newly accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contents.delete();
			results_due.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					note_failure($sformatf("result word with none owed: status %0d found %0d count %0d",
						result.status, result.found, result.count));
				end else begin
					due = results_due.pop_front();
					if (result.status !== due.status || result.found !== due.found ||
							result.count !== due.count)
						note_failure($sformatf(
							"result word: status %0d/%0d found %0d/%0d count %0d/%0d (exp/got)",
							due.status, result.status, due.found, result.found,
							due.count, result.count));
				end
			end
			if (start && !busy) results_due.push_back(apply_command(item));
			pending = results_due.size();
		end
	end

endmodule

/* sim/tb_indexed_deque_list_unit.sv */
// Testbench top for the indexed deque list unit: stimulus, clock, reset and verdict.
module tb_indexed_deque_list_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import idl_pkg::*;

	localparam int DEPTH        = 256;
	localparam int RANDOM_WORDS = 390;
	localparam int RUN_LIMIT    = 5000000;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;
	int      fail_count;
	int      words_pending;

	// Element count as the stimulus sees it, used only to steer the mix.
	int held;
	int idle_pct;
	int cycle_count;
	logic signed [DATA_W-1:0] value_pool [16];

	indexed_deque_list_unit #(.CAPACITY(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	idl_list_checker #(.CAPACITY(DEPTH)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.item       (item),
		.done       (done),
		.result     (result),
		.mismatches (fail_count),
		.pending    (words_pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Guard against a hang.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Present one word after a random gap and hold it until it is taken.
	task automatic send_word(input cmd_t op, input logic signed [DATA_W-1:0] v,
			input logic [7:0] p);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item <= '{command: op, data_value: v, position: p};
		do @(posedge clk); while (busy);
		// Follow the count so later words can aim at valid positions.
		case (op)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: if (held < DEPTH) held++;
			CMD_INSERT: if (held > 0 && p != 0 && p < held && held < DEPTH) held++;
			CMD_POP_FRONT, CMD_POP_BACK: if (held > 0) held--;
			CMD_DELETE: if (held > 0 && p != 0 && p < held) held--;
			default: begin
			end
		endcase
	endtask

	// Values half the time from a small pool so that searches hit.
	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(1) == 1) return value_pool[$urandom_range(15)];
		return $urandom();
	endfunction

	// Positions mostly inside the list, the rest at or past its edges.
	function automatic logic [7:0] pick_position();
		int r;
		r = $urandom_range(99);
		if (held > 1 && r < 75) return 8'($urandom_range(held - 1, 1));
		if (r < 82) return 8'd0;
		if (r < 89) return 8'(held);
		if (r < 94) return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// One random word; grow_pct sets the odds of an adding over a removing command.
	task automatic random_word(input int grow_pct);
		int   r;
		logic grow;
		cmd_t op;
		r = $urandom_range(99);
		grow = ($urandom_range(99) < grow_pct);
		if (r < 4) op = CMD_NONE;
		else if (r < 16) op = CMD_SEARCH;
		else begin
			case ($urandom_range(2))
				0: op = grow ? CMD_PUSH_FRONT : CMD_POP_FRONT;
				1: op = grow ? CMD_INSERT : CMD_DELETE;
				default: op = grow ? CMD_PUSH_BACK : CMD_POP_BACK;
			endcase
		end
		send_word(op, pick_value(), pick_position());
	endtask

	// A run of random words that wanders between short lists and empty.
	task automatic run_phase(input int pct);
		int target;
		idle_pct = pct;
		target = 0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 0) target = ($urandom_range(5) == 0) ? 0 : $urandom_range(48);
			random_word((held < target) ? 70 : 30);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		held = 0;
		idle_pct = 0;
		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7FFF_FFFF;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < 16; i++) value_pool[i] = $urandom();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Errors on the empty list, then the field extremes and edge positions.
		send_word(CMD_POP_FRONT, 32'sd5, 8'd0);
		send_word(CMD_POP_BACK, 32'sd5, 8'd0);
		send_word(CMD_DELETE, 32'sd5, 8'd1);
		send_word(CMD_INSERT, 32'sd5, 8'd1);
		send_word(CMD_SEARCH, 32'sd0, 8'd0);
		send_word(CMD_NONE, 32'sh7FFF_FFFF, 8'hFF);
		send_word(CMD_PUSH_BACK, 32'sh7FFF_FFFF, 8'hFF);
		send_word(CMD_PUSH_FRONT, 32'sh8000_0000, 8'd0);
		send_word(CMD_PUSH_BACK, -32'sd1, 8'd0);
		send_word(CMD_SEARCH, 32'sh8000_0000, 8'd0);
		send_word(CMD_SEARCH, 32'sd0, 8'd0);
		send_word(CMD_INSERT, 32'sd7, 8'd0);
		send_word(CMD_INSERT, 32'sd7, 8'd3);
		send_word(CMD_INSERT, 32'sd7, 8'hFF);
		send_word(CMD_INSERT, 32'sd0, 8'd1);
		send_word(CMD_INSERT, 32'sd12345, 8'd3);
		send_word(CMD_DELETE, 32'sd0, 8'd0);
		send_word(CMD_DELETE, 32'sd0, 8'd5);
		send_word(CMD_DELETE, 32'sd0, 8'd4);
		send_word(CMD_DELETE, 32'sd0, 8'd1);
		send_word(CMD_SEARCH, -32'sd1, 8'd0);
		send_word(CMD_POP_FRONT, 32'sd0, 8'd0);
		send_word(CMD_POP_BACK, 32'sd0, 8'd0);
		send_word(CMD_SEARCH, 32'sd12345, 8'd0);
		send_word(CMD_NONE, 32'sd0, 8'd0);

		// Fill to capacity, work the full list, then drain it to twelve elements.
		while (held < DEPTH) random_word(90);
		repeat (15) random_word(85);
		while (held > 12) random_word(10);

		run_phase(0);
		run_phase(80);
		run_phase(6);

		@(negedge clk);
		start <= 1'b0;
		wait (words_pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
